// ===== src/signed_radix_digit_emitter_core_assert.svh =====
// Assertion macros shared by the emitter RTL.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SRDE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SRDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/srde_pkg.sv =====
package srde_pkg;

	localparam int unsigned MAX_RADIX_DEF  = 16;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// bits of dividend consumed per divider cycle
	localparam int unsigned DIV_STEP = 8;

	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned PDATA_W   = 64;
	localparam int unsigned REG_SHIFT = 3;
	localparam int unsigned REG_IDX_W = PADDR_W - REG_SHIFT;

	localparam int unsigned RADIX_W   = 5;
	localparam int unsigned SYM_REG_W = 64;
	localparam int unsigned SYM_W     = 7;

	localparam logic [REG_IDX_W-1:0] REG_RADIX    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

	localparam logic [7:0] CH_MIN     = 8'd33;
	localparam logic [7:0] CH_MAX     = 8'd126;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_STAR    = 8'h2a;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_EQUAL   = 8'h3d;

	localparam logic [SYM_W-1:0] SYM_MINUS = CH_MINUS[SYM_W-1:0];
	localparam logic [SYM_W-1:0] SYM_NONE  = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_PRE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		KIND_MINUS,
		KIND_DIGIT,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic start;
		logic chain;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
		logic quot_zero;
	} div_stat_t;

	function automatic logic is_forbidden(input logic [7:0] c);
		logic bad;
		bad = (c < CH_MIN) || (c > CH_MAX);
		bad = bad || (c inside {CH_PLUS, CH_MINUS, CH_PERCENT, CH_SLASH,
			CH_STAR, CH_COMMA, CH_DOT, CH_EQUAL});
		return bad;
	endfunction

	function automatic logic [7:0] sym_byte(input logic [SYM_REG_W-1:0] lo,
			input logic [SYM_REG_W-1:0] hi, input logic [3:0] idx);
		logic [2*SYM_REG_W-1:0] all;
		all = {hi, lo};
		return all[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ===== src/signed_radix_digit_emitter_core.sv =====
// A value word has the alphabet checked, then is divided by the radix once for each digit;
// the shared divider takes a byte of magnitude a cycle; the top digit is then prefetched.
// Symbol words leave one a cycle while not stalled; a bad alphabet gives one error word.
// Throughput: one value at a time, the next taken once the last symbol word is taken.
// Reset: arst_n clears the sequencer and the config registers; the digit RAM is not cleared.
`include "signed_radix_digit_emitter_core_assert.svh"

module signed_radix_digit_emitter_core #(
	parameter int unsigned MAX_RADIX  = srde_pkg::MAX_RADIX_DEF,
	parameter int unsigned VALUE_BITS = srde_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [srde_pkg::PADDR_W-1:0]   paddr,
	input  logic [srde_pkg::PDATA_W-1:0]   pwdata,
	output logic [srde_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           value_valid,
	output logic                           value_stall,
	input  logic signed [VALUE_BITS-1:0]   value,
	output logic                           symbol_valid,
	input  logic                           symbol_stall,
	output logic [srde_pkg::SYM_W-1:0]     symbol,
	output logic                           last,
	output logic                           error
);

	localparam int unsigned STEP    = srde_pkg::DIV_STEP;
	localparam int unsigned DIV_CYC = (VALUE_BITS + STEP - 1) / STEP;
	localparam int unsigned DIV_W   = DIV_CYC * STEP;
	localparam int unsigned DIG_W   = $clog2(MAX_RADIX);
	localparam int unsigned PART_W  = DIG_W + 1;
	localparam int unsigned ADDR_W  = $clog2(VALUE_BITS);
	localparam int unsigned ND_W    = $clog2(VALUE_BITS + 1);

	// config registers
	logic [srde_pkg::RADIX_W-1:0]   radix_q;
	logic [srde_pkg::SYM_REG_W-1:0] sym_lo_q;
	logic [srde_pkg::SYM_REG_W-1:0] sym_hi_q;
	logic [srde_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           cfg_wr;

	// sequencer
	srde_pkg::state_t state_q, state_d;
	srde_pkg::kind_t  kind_q, kind_d;
	logic [ND_W-1:0]       nd_q, nd_d;
	logic [ND_W-1:0]       nd_dec;
	logic [ADDR_W-1:0]     ptr_q, ptr_d;
	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] mag;

	logic                  alpha_ok;
	srde_pkg::div_ctrl_t   div_ctrl;
	srde_pkg::div_stat_t   div_stat;
	logic [DIG_W-1:0]      digit;
	logic [7:0]            digit_byte;

	logic                  wr_en;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [srde_pkg::SYM_W-1:0] rd_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[srde_pkg::PADDR_W-1:srde_pkg::REG_SHIFT];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				srde_pkg::REG_RADIX:    radix_q  <= pwdata[srde_pkg::RADIX_W-1:0];
				srde_pkg::REG_SYM_LOW:  sym_lo_q <= pwdata;
				srde_pkg::REG_SYM_HIGH: sym_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			srde_pkg::REG_RADIX:    prdata = srde_pkg::PDATA_W'(radix_q);
			srde_pkg::REG_SYM_LOW:  prdata = sym_lo_q;
			srde_pkg::REG_SYM_HIGH: prdata = sym_hi_q;
			default:                prdata = '0;
		endcase
	end

	srde_alpha_chk #(
		.MAX_RADIX(MAX_RADIX)
	) u_alpha_chk (
		.radix       (radix_q),
		.symbols_low (sym_lo_q),
		.symbols_high(sym_hi_q),
		.ok          (alpha_ok)
	);

	// two's-complement magnitude: the most negative value stays correct as unsigned
	assign mag = value_q[VALUE_BITS-1] ? (~value_q + VALUE_BITS'(1)) : value_q;

	srde_div #(
		.MAX_RADIX (MAX_RADIX),
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (div_ctrl),
		.dividend(DIV_W'(mag)),
		.divisor (radix_q[PART_W-1:0]),
		.stat    (div_stat),
		.digit   (digit)
	);

	assign digit_byte = srde_pkg::sym_byte(sym_lo_q, sym_hi_q, 4'(digit));

	// digits land least significant first, read back in reverse
	srde_ram #(
		.WIDTH(srde_pkg::SYM_W),
		.DEPTH(VALUE_BITS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(nd_q[ADDR_W-1:0]),
		.wr_data(digit_byte[srde_pkg::SYM_W-1:0]),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign nd_dec = nd_q - ND_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srde_pkg::ST_IDLE;
			kind_q  <= srde_pkg::KIND_DIGIT;
			nd_q    <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			nd_q    <= nd_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (value_valid && !value_stall) begin
			value_q <= value;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		nd_d     = nd_q;
		ptr_d    = ptr_q;
		div_ctrl = '0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = ptr_q;
		case (state_q)
			srde_pkg::ST_IDLE: begin
				if (value_valid) begin
					state_d = srde_pkg::ST_CHECK;
				end
			end
			srde_pkg::ST_CHECK: begin
				if (!alpha_ok) begin
					kind_d  = srde_pkg::KIND_ERROR;
					state_d = srde_pkg::ST_EMIT;
				end else begin
					div_ctrl.start = 1'b1;
					nd_d           = '0;
					state_d        = srde_pkg::ST_DIV;
				end
			end
			srde_pkg::ST_DIV: begin
				if (div_stat.done) begin
					wr_en = 1'b1;
					nd_d  = nd_q + ND_W'(1);
					if (!div_stat.quot_zero) begin
						div_ctrl.start = 1'b1;
						div_ctrl.chain = 1'b1;
					end else begin
						state_d = srde_pkg::ST_PRE;
					end
				end
			end
			srde_pkg::ST_PRE: begin
				rd_en   = 1'b1;
				rd_addr = nd_dec[ADDR_W-1:0];
				ptr_d   = nd_dec[ADDR_W-1:0];
				kind_d  = value_q[VALUE_BITS-1] ? srde_pkg::KIND_MINUS : srde_pkg::KIND_DIGIT;
				state_d = srde_pkg::ST_EMIT;
			end
			srde_pkg::ST_EMIT: begin
				if (!symbol_stall) begin
					if (last) begin
						state_d = srde_pkg::ST_IDLE;
					end else if (kind_q == srde_pkg::KIND_MINUS) begin
						kind_d = srde_pkg::KIND_DIGIT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ptr_q - ADDR_W'(1);
						ptr_d   = ptr_q - ADDR_W'(1);
					end
				end
			end
			default: begin
				state_d = srde_pkg::ST_IDLE;
			end
		endcase
	end

	assign value_stall  = (state_q != srde_pkg::ST_IDLE);
	assign symbol_valid = (state_q == srde_pkg::ST_EMIT);
	assign error        = (kind_q == srde_pkg::KIND_ERROR);
	assign last         = error || ((kind_q == srde_pkg::KIND_DIGIT) && (ptr_q == '0));

	always_comb begin
		case (kind_q)
			srde_pkg::KIND_MINUS: symbol = srde_pkg::SYM_MINUS;
			srde_pkg::KIND_DIGIT: symbol = rd_data;
			default:              symbol = srde_pkg::SYM_NONE;
		endcase
	end

	`SRDE_ASSERT_SAME(a_div_done_in_div, div_stat.done, state_q == srde_pkg::ST_DIV, "divider result outside digit phase")
	`SRDE_ASSERT_SAME(a_digit_wr_in_range, wr_en, nd_q < ND_W'(VALUE_BITS), "digit store overrun")
	`SRDE_ASSERT_SAME(a_ptr_in_range, (state_q == srde_pkg::ST_EMIT) && (kind_q == srde_pkg::KIND_DIGIT), ND_W'(ptr_q) < nd_q, "read pointer beyond stored digits")
	`SRDE_ASSERT_NEXT(a_last_ends_run, symbol_valid && !symbol_stall && last, state_q == srde_pkg::ST_IDLE, "run did not end after last word")

endmodule

// ===== src/srde_ram.sv =====
module srde_ram #(
	parameter int unsigned WIDTH = srde_pkg::SYM_W,
	parameter int unsigned DEPTH = srde_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                   wr_data,
	input  logic                               rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                   rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/srde_alpha_chk.sv =====
module srde_alpha_chk #(
	parameter int unsigned MAX_RADIX = srde_pkg::MAX_RADIX_DEF
) (
	input  logic [srde_pkg::RADIX_W-1:0]   radix,
	input  logic [srde_pkg::SYM_REG_W-1:0] symbols_low,
	input  logic [srde_pkg::SYM_REG_W-1:0] symbols_high,
	output logic                           ok
);

	logic [MAX_RADIX-1:0] lane_bad;

	// one lane per symbol: range, reserved set, clash with any lower symbol
	always_comb begin
		logic [7:0] sk;
		for (int k = 0; k < MAX_RADIX; k++) begin
			sk = srde_pkg::sym_byte(symbols_low, symbols_high, 4'(k));
			lane_bad[k] = srde_pkg::is_forbidden(sk);
			for (int j = 0; j < k; j++) begin
				lane_bad[k] = lane_bad[k] ||
					(srde_pkg::sym_byte(symbols_low, symbols_high, 4'(j)) == sk);
			end
			lane_bad[k] = lane_bad[k] && (srde_pkg::RADIX_W'(k) < radix);
		end
	end

	assign ok = (radix >= srde_pkg::MIN_RADIX) &&
		(radix <= srde_pkg::RADIX_W'(MAX_RADIX)) && !(|lane_bad);

endmodule

// ===== src/srde_div.sv =====
module srde_div #(
	parameter int unsigned MAX_RADIX  = srde_pkg::MAX_RADIX_DEF,
	parameter int unsigned VALUE_BITS = srde_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srde_pkg::div_ctrl_t     ctrl,
	input  logic [((VALUE_BITS + srde_pkg::DIV_STEP - 1) / srde_pkg::DIV_STEP)
		* srde_pkg::DIV_STEP - 1:0] dividend,
	input  logic [$clog2(MAX_RADIX):0] divisor,
	output srde_pkg::div_stat_t     stat,
	output logic [$clog2(MAX_RADIX)-1:0] digit
);

	localparam int unsigned STEP    = srde_pkg::DIV_STEP;
	localparam int unsigned DIV_CYC = (VALUE_BITS + STEP - 1) / STEP;
	localparam int unsigned DIV_W   = DIV_CYC * STEP;
	localparam int unsigned DIG_W   = $clog2(MAX_RADIX);
	localparam int unsigned PART_W  = DIG_W + 1;
	localparam int unsigned CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	logic [DIV_W-1:0] work_q;
	logic [DIG_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [STEP-1:0]  chunk;
	logic [STEP-1:0]  qbits;
	logic [DIG_W-1:0] rem_n;
	logic [DIV_W-1:0] work_shift;

	assign chunk = work_q[DIV_W-1 -: STEP];

	// restoring long division, one byte of the dividend a cycle
	always_comb begin
		logic [PART_W-1:0] part;
		rem_n = rem_q;
		qbits = '0;
		for (int b = STEP - 1; b >= 0; b--) begin
			part = {rem_n, chunk[b]};
			if (part >= divisor) begin
				qbits[b] = 1'b1;
				part = part - divisor;
			end
			rem_n = part[DIG_W-1:0];
		end
	end

	generate
		if (DIV_CYC > 1) begin : g_shift
			assign work_shift = {work_q[DIV_W-STEP-1:0], qbits};
		end else begin : g_single
			assign work_shift = qbits;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// chain restarts on the quotient left in work_q
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			if (!ctrl.chain) begin
				work_q <= dividend;
			end
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= work_shift;
			rem_q  <= rem_n;
		end
	end

	assign stat.done      = done_q;
	assign stat.quot_zero = (work_q == '0);
	assign digit          = rem_q;

endmodule
